>>> rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants of the top-k smallest selector
// Request and register codes, default sizes, and the control word that the
// controller hands to the sorted cell chain.
// ----------------------------------------------------------------------------
package tks_pkg;

  // Fixed widths of the port fields
  localparam int KEY_PORT_W = 64;
  localparam int ROW_PORT_W = 32;
  localparam int REQ_W      = 2;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;

  // Occupancy wide enough for the largest supported capacity (64)
  localparam int OCC_W = 7;

  // Defaults for the top-level parameters
  localparam int DEF_CAPACITY = 64;
  localparam int DEF_KEY_BITS = 64;
  localparam int DEF_ROW_BITS = 32;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SCAN   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] KEEP_COUNT_RST = 7'd64;
  localparam logic [CFG_W-1:0] SKIP_COUNT_RST = 7'd0;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  // occ_cur: entries held now (compare, boundary, rotate wrap)
  // occ_ins: entries that take part in an insert (occ_cur less one on eviction)
  typedef struct packed {
    cell_op_t         op;
    logic [OCC_W-1:0] occ_cur;
    logic [OCC_W-1:0] occ_ins;
  } chain_ctl_t;

endpackage

>>> rtl/tks_cell.sv
// ----------------------------------------------------------------------------
// tks_cell: one slot of the sorted chain
// Holds one key and row; on insert it keeps, takes its left neighbor or takes
// the new entry; on rotate it takes its right neighbor or wraps to the head.
// ----------------------------------------------------------------------------
module tks_cell #(
  parameter int KEY_BITS = tks_pkg::DEF_KEY_BITS,
  parameter int ROW_BITS = tks_pkg::DEF_ROW_BITS
) (
  input  logic                 clk,
  input  tks_pkg::cell_op_t    op,
  input  logic                 active,
  input  logic                 prev_gt,
  input  logic                 wrap,
  input  logic [KEY_BITS-1:0]  new_key,
  input  logic [ROW_BITS-1:0]  new_row,
  input  logic [KEY_BITS-1:0]  left_key,
  input  logic [ROW_BITS-1:0]  left_row,
  input  logic [KEY_BITS-1:0]  right_key,
  input  logic [ROW_BITS-1:0]  right_row,
  input  logic [KEY_BITS-1:0]  head_key,
  input  logic [ROW_BITS-1:0]  head_row,
  output logic [KEY_BITS-1:0]  key_q,
  output logic [ROW_BITS-1:0]  row_q,
  output logic                 gt
);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt;

  // Strictly greater: an equal key stays ahead of the new one
  assign gt = key_r > new_key;

  always_comb begin
    key_nxt = key_r;
    row_nxt = row_r;
    case (op)
      tks_pkg::CELL_INSERT: begin
        if (active && !gt) begin
          key_nxt = key_r;
          row_nxt = row_r;
        end else if (prev_gt) begin
          key_nxt = left_key;
          row_nxt = left_row;
        end else begin
          key_nxt = new_key;
          row_nxt = new_row;
        end
      end
      tks_pkg::CELL_ROTATE: begin
        if (wrap) begin
          key_nxt = head_key;
          row_nxt = head_row;
        end else begin
          key_nxt = right_key;
          row_nxt = right_row;
        end
      end
      default: begin
        key_nxt = key_r;
        row_nxt = row_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    row_r <= row_nxt;
  end

  assign key_q = key_r;
  assign row_q = row_r;

endmodule

>>> rtl/tks_chain.sv
// ----------------------------------------------------------------------------
// tks_chain: row of sorted cells
// Wires the cells to their neighbors, derives per-cell position flags from
// the occupancy, and picks out the head and the boundary (largest) entry.
// ----------------------------------------------------------------------------
module tks_chain #(
  parameter int CAPACITY = tks_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = tks_pkg::DEF_KEY_BITS,
  parameter int ROW_BITS = tks_pkg::DEF_ROW_BITS
) (
  input  logic                 clk,
  input  tks_pkg::chain_ctl_t  ctl,
  input  logic [KEY_BITS-1:0]  new_key,
  input  logic [ROW_BITS-1:0]  new_row,
  output logic [KEY_BITS-1:0]  head_key,
  output logic [ROW_BITS-1:0]  head_row,
  output logic [KEY_BITS-1:0]  bound_key,
  output logic                 any_gt
);

  logic [KEY_BITS-1:0] key_q   [CAPACITY];
  logic [ROW_BITS-1:0] row_q   [CAPACITY];
  logic                gt      [CAPACITY];
  logic                active  [CAPACITY];
  logic                held    [CAPACITY];
  logic                is_last [CAPACITY];

  assign head_key = key_q[0];
  assign head_row = row_q[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                prev_gt;
    logic [KEY_BITS-1:0] left_key;
    logic [ROW_BITS-1:0] left_row;
    logic [KEY_BITS-1:0] right_key;
    logic [ROW_BITS-1:0] right_row;

    assign active[i]  = tks_pkg::OCC_W'(i) < ctl.occ_ins;
    assign held[i]    = tks_pkg::OCC_W'(i) < ctl.occ_cur;
    assign is_last[i] = tks_pkg::OCC_W'(i + 1) == ctl.occ_cur;

    if (i == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign left_key = new_key;
      assign left_row = new_row;
    end else begin : g_inner
      assign prev_gt  = gt[i-1] && active[i-1];
      assign left_key = key_q[i-1];
      assign left_row = row_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_key = key_q[0];
      assign right_row = row_q[0];
    end else begin : g_mid
      assign right_key = key_q[i+1];
      assign right_row = row_q[i+1];
    end

    tks_cell #(
      .KEY_BITS (KEY_BITS),
      .ROW_BITS (ROW_BITS)
    ) u_cell (
      .clk       (clk),
      .op        (ctl.op),
      .active    (active[i]),
      .prev_gt   (prev_gt),
      .wrap      (is_last[i]),
      .new_key   (new_key),
      .new_row   (new_row),
      .left_key  (left_key),
      .left_row  (left_row),
      .right_key (right_key),
      .right_row (right_row),
      .head_key  (key_q[0]),
      .head_row  (row_q[0]),
      .key_q     (key_q[i]),
      .row_q     (row_q[i]),
      .gt        (gt[i])
    );
  end

  // Boundary is the held entry in the last occupied slot
  always_comb begin
    bound_key = '0;
    any_gt    = 1'b0;
    for (int j = 0; j < CAPACITY; j++) begin
      bound_key = bound_key | (key_q[j] & {KEY_BITS{is_last[j]}});
      any_gt    = any_gt | (gt[j] & held[j]);
    end
  end

endmodule

>>> rtl/top_k_smallest_selector.sv
// ----------------------------------------------------------------------------
// top_k_smallest_selector: keeps the smallest keys seen, in a sorted cell chain
// Insert: accept, a chain update in the execute state, then the status result.
// Scan: accept, a check in the execute state, then one chain rotation per held entry;
//   entries past skip_count leave one per cycle while the output slot is free.
// Clear and unused codes give no result.
// One request is in flight at a time; the chain update and rotation set it.
// Reset (rst_n low, synchronous) empties the store and restores keep 64, skip 0.
// ----------------------------------------------------------------------------
module top_k_smallest_selector #(
  parameter int CAPACITY = tks_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = tks_pkg::DEF_KEY_BITS,
  parameter int ROW_BITS = tks_pkg::DEF_ROW_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [tks_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tks_pkg::CFG_W-1:0]         cfg_wdata,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tks_pkg::REQ_W-1:0]         in_req_type,
  input  logic [tks_pkg::KEY_PORT_W-1:0]    in_sort_key,
  input  logic [tks_pkg::ROW_PORT_W-1:0]    in_row_index,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_result_kind,
  output logic                              out_accepted,
  output logic                              out_store_full,
  output logic [tks_pkg::KEY_PORT_W-1:0]    out_key,
  output logic [tks_pkg::ROW_PORT_W-1:0]    out_row,
  output logic                              out_last
);

  localparam int OCC_W = tks_pkg::OCC_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STAT,
    ST_SCAN
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [tks_pkg::CFG_W-1:0] keep_r;
  logic [tks_pkg::CFG_W-1:0] skip_r;

  // Latched request
  logic [tks_pkg::REQ_W-1:0] req_r;
  logic [KEY_BITS-1:0]       key_r;
  logic [ROW_BITS-1:0]       row_r;

  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] pos_r;
  logic             acc_r;

  // Output register
  logic                           out_valid_r;
  logic                           kind_r;
  logic                           accepted_r;
  logic                           full_r;
  logic [tks_pkg::KEY_PORT_W-1:0] okey_r;
  logic [tks_pkg::ROW_PORT_W-1:0] orow_r;
  logic                           last_r;

  // Chain hookup
  tks_pkg::chain_ctl_t ctl;
  logic [KEY_BITS-1:0] head_key;
  logic [ROW_BITS-1:0] head_row;
  logic [KEY_BITS-1:0] bound_key;
  logic                any_gt;

  // Store limit: keep plus skip, saturated at the capacity
  logic [OCC_W:0]   limit_sum;
  logic [OCC_W-1:0] limit;
  logic             full_now;

  logic in_fire;
  logic out_free;
  logic out_load;
  logic room;
  logic evict;
  logic do_insert;
  logic scan_step;
  logic scan_emit;
  logic scan_done;
  logic scan_none;

  logic [ROW_BITS+tks_pkg::ROW_PORT_W-1:0] row_in_wide;
  logic [ROW_BITS+tks_pkg::ROW_PORT_W-1:0] row_out_wide;

  assign limit_sum = {1'b0, keep_r} + {1'b0, skip_r};
  assign limit     = (limit_sum > (OCC_W + 1)'(CAPACITY)) ? OCC_W'(CAPACITY)
                                                           : limit_sum[OCC_W-1:0];
  assign full_now  = occ_r >= limit;

  assign in_ready = state_r == ST_IDLE;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Widen the row through a zero pad so any ROW_BITS works both ways
  assign row_in_wide  = {{ROW_BITS{1'b0}}, in_row_index};
  assign row_out_wide = {{tks_pkg::ROW_PORT_W{1'b0}}, head_row};

  // Insert decision: room left, or full and the new key beats the boundary
  assign room      = occ_r < limit;
  assign evict     = !room && (occ_r != '0) && any_gt;
  assign do_insert = (state_r == ST_EXEC) && (req_r == tks_pkg::REQ_INSERT) &&
                     (room || evict);

  // Scan: rotate once per held entry; skipped positions never wait on output
  assign scan_none = (keep_r == '0) || ({1'b0, skip_r} >= {1'b0, occ_r});
  assign scan_step = (state_r == ST_SCAN) && ((pos_r < skip_r) || out_free);
  assign scan_emit = scan_step && (pos_r >= skip_r);
  assign scan_done = scan_step && (pos_r == occ_r - OCC_W'(1));

  // A new result enters the output register this cycle
  assign out_load = ((state_r == ST_STAT) && out_free) || scan_emit;

  always_comb begin
    ctl.occ_cur = occ_r;
    ctl.occ_ins = evict ? occ_r - OCC_W'(1) : occ_r;
    ctl.op      = tks_pkg::CELL_HOLD;
    if (do_insert) begin
      ctl.op = tks_pkg::CELL_INSERT;
    end else if (scan_step) begin
      ctl.op = tks_pkg::CELL_ROTATE;
    end
  end

  tks_chain #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .ROW_BITS (ROW_BITS)
  ) u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .new_key   (key_r),
    .new_row   (row_r),
    .head_key  (head_key),
    .head_row  (head_row),
    .bound_key (bound_key),
    .any_gt    (any_gt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      keep_r      <= tks_pkg::KEEP_COUNT_RST;
      skip_r      <= tks_pkg::SKIP_COUNT_RST;
      occ_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Configuration writes land at once
      if (cfg_wr_en) begin
        unique case (cfg_index)
          tks_pkg::REG_KEEP_COUNT: keep_r <= cfg_wdata;
          tks_pkg::REG_SKIP_COUNT: skip_r <= cfg_wdata;
          default: ;
        endcase
      end

      // Drop the result once it is taken, unless a new one loads below
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            req_r   <= in_req_type;
            key_r   <= in_sort_key[KEY_BITS-1:0];
            row_r   <= row_in_wide[ROW_BITS-1:0];
            state_r <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          case (req_r)
            tks_pkg::REQ_INSERT: begin
              acc_r <= room || evict;
              if (room) begin
                occ_r <= occ_r + OCC_W'(1);
              end
              state_r <= ST_STAT;
            end
            tks_pkg::REQ_SCAN: begin
              pos_r   <= '0;
              state_r <= scan_none ? ST_IDLE : ST_SCAN;
            end
            tks_pkg::REQ_CLEAR: begin
              occ_r   <= '0;
              state_r <= ST_IDLE;
            end
            default: begin
              state_r <= ST_IDLE;
            end
          endcase
        end

        ST_STAT: begin
          // Hold the status until the output slot frees up
          if (out_free) begin
            out_valid_r <= 1'b1;
            kind_r      <= tks_pkg::KIND_STATUS;
            accepted_r  <= acc_r;
            full_r      <= full_now;
            okey_r      <= (occ_r == '0) ? '0 : tks_pkg::KEY_PORT_W'(bound_key);
            orow_r      <= '0;
            last_r      <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end

        ST_SCAN: begin
          if (scan_emit) begin
            out_valid_r <= 1'b1;
            kind_r      <= tks_pkg::KIND_ENTRY;
            accepted_r  <= 1'b0;
            full_r      <= full_now;
            okey_r      <= tks_pkg::KEY_PORT_W'(head_key);
            orow_r      <= row_out_wide[tks_pkg::ROW_PORT_W-1:0];
            last_r      <= scan_done;
          end
          if (scan_step) begin
            pos_r <= pos_r + OCC_W'(1);
          end
          if (scan_done) begin
            state_r <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_accepted    = accepted_r;
  assign out_store_full  = full_r;
  assign out_key         = okey_r;
  assign out_row         = orow_r;
  assign out_last        = last_r;

  // Occupancy never passes the capacity
  a_occ_cap: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  // Occupancy moves only in the execute cycle
  a_occ_still: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_EXEC) |=> $stable(occ_r))
    else $error("occupancy changed outside execute");

  // An insert never shrinks the store
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && req_r == tks_pkg::REQ_INSERT) |=> occ_r >= $past(occ_r))
    else $error("insert shrank the store");

  // The scan position stays within the held entries
  a_scan_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (pos_r < occ_r))
    else $error("scan position past occupancy");

  // A status result always closes its request
  a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == tks_pkg::KIND_STATUS) |-> last_r)
    else $error("status result without last");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the top-k smallest selector
// A queue of planned requests and register writes feeds a valid/ready driver.
// An in-bench copy of the sorted store predicts every status and scanned entry
// at request acceptance. A monitor compares each result in order. Both sides
// insert random gaps, and register writes go in only while the block is quiet.
// ----------------------------------------------------------------------------
module tb;

  localparam int SLOTS        = tks_pkg::DEF_CAPACITY;
  // Long enough to outlast a full-store scan, so this covers a silent scan too
  localparam int QUIET_CYCLES = 80;
  localparam int ITEM_TARGET  = 450;
  // The one request code that the block ignores
  localparam logic [tks_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    DO_REQUEST,
    DO_WRITE,
    DO_DRAIN
  } plan_kind_t;

  typedef struct {
    plan_kind_t                       kind;
    logic [tks_pkg::REQ_W-1:0]        req;
    logic [tks_pkg::KEY_PORT_W-1:0]   key;
    logic [tks_pkg::ROW_PORT_W-1:0]   row;
    logic [tks_pkg::CFG_IDX_W-1:0]    reg_idx;
    logic [tks_pkg::CFG_W-1:0]        reg_val;
  } plan_step_t;

  typedef struct packed {
    logic                             kind;
    logic                             acc;
    logic                             full;
    logic [tks_pkg::KEY_PORT_W-1:0]   key;
    logic [tks_pkg::ROW_PORT_W-1:0]   row;
    logic                             last;
  } result_t;

  logic                            clk          = 1'b0;
  logic                            rst_n        = 1'b0;
  logic                            cfg_wr_en    = 1'b0;
  logic [tks_pkg::CFG_IDX_W-1:0]   cfg_index    = '0;
  logic [tks_pkg::CFG_W-1:0]       cfg_wdata    = '0;
  logic                            in_valid     = 1'b0;
  logic                            in_ready;
  logic [tks_pkg::REQ_W-1:0]       in_req_type  = '0;
  logic [tks_pkg::KEY_PORT_W-1:0]  in_sort_key  = '0;
  logic [tks_pkg::ROW_PORT_W-1:0]  in_row_index = '0;
  logic                            out_valid;
  logic                            out_ready    = 1'b0;
  logic                            out_result_kind;
  logic                            out_accepted;
  logic                            out_store_full;
  logic [tks_pkg::KEY_PORT_W-1:0]  out_key;
  logic [tks_pkg::ROW_PORT_W-1:0]  out_row;
  logic                            out_last;

  top_k_smallest_selector u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_sort_key     (in_sort_key),
    .in_row_index    (in_row_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_accepted    (out_accepted),
    .out_store_full  (out_store_full),
    .out_key         (out_key),
    .out_row         (out_row),
    .out_last        (out_last)
  );

  always #4 clk = ~clk;

  // Planned stimulus, and the results the block still owes
  plan_step_t request_plan [$];
  result_t    due_results  [$];
  int         planned_items = 0;
  int         fault_count   = 0;

  // Bench copy of the sorted store and its two limits
  logic [tks_pkg::KEY_PORT_W-1:0] held_key [SLOTS];
  logic [tks_pkg::ROW_PORT_W-1:0] held_row [SLOTS];
  int                             held_cnt = 0;
  int                             keep_lim = tks_pkg::KEEP_COUNT_RST;
  int                             skip_lim = tks_pkg::SKIP_COUNT_RST;

  // Pacing state of the two sides
  int quiet_run  = 0;
  int send_pause = 0;
  bit send_calm  = 1'b0;
  int recv_pause = 0;
  bit recv_calm  = 1'b0;

  // Store size limit: keep plus skip, saturated at the capacity
  function automatic int store_cap();
    int sum;
    sum = keep_lim + skip_lim;
    return (sum > SLOTS) ? SLOTS : sum;
  endfunction

  // Place a key after every held key that is not larger (ties keep order)
  task automatic place_entry(input logic [tks_pkg::KEY_PORT_W-1:0] key,
                             input logic [tks_pkg::ROW_PORT_W-1:0] row);
    int pos;
    pos = held_cnt;
    if (held_cnt >= SLOTS) return;
    while (pos > 0 && held_key[pos-1] > key) begin
      held_key[pos] = held_key[pos-1];
      held_row[pos] = held_row[pos-1];
      pos--;
    end
    held_key[pos] = key;
    held_row[pos] = row;
    held_cnt++;
  endtask

  // Apply one accepted request to the store and queue the results it owes
  task automatic update_selection(input logic [tks_pkg::REQ_W-1:0]      req,
                                  input logic [tks_pkg::KEY_PORT_W-1:0] key,
                                  input logic [tks_pkg::ROW_PORT_W-1:0] row);
    result_t r;
    int      cap;
    logic    took;
    int      i;
    cap = store_cap();
    case (req)
      tks_pkg::REQ_INSERT: begin
        took = 1'b0;
        if (held_cnt < cap) begin
          place_entry(key, row);
          took = 1'b1;
        end else if (held_cnt > 0 && key < held_key[held_cnt-1]) begin
          // Evict the latest of the largest keys, then insert
          held_cnt--;
          place_entry(key, row);
          took = 1'b1;
        end
        r.kind = tks_pkg::KIND_STATUS;
        r.acc  = took;
        r.full = (held_cnt >= cap);
        r.key  = (held_cnt > 0) ? held_key[held_cnt-1] : '0;
        r.row  = '0;
        r.last = 1'b1;
        due_results = {due_results, r};
      end
      tks_pkg::REQ_SCAN: begin
        if (keep_lim != 0 && skip_lim < held_cnt) begin
          for (i = skip_lim; i < held_cnt; i++) begin
            r.kind = tks_pkg::KIND_ENTRY;
            r.acc  = 1'b0;
            r.full = (held_cnt >= cap);
            r.key  = held_key[i];
            r.row  = held_row[i];
            r.last = (i == held_cnt - 1);
            due_results = {due_results, r};
          end
        end
      end
      tks_pkg::REQ_CLEAR: held_cnt = 0;
      default: ;
    endcase
  endtask

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_pause(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Keys: small values for ties and evictions, wide randoms, and the extremes
  function automatic logic [tks_pkg::KEY_PORT_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return tks_pkg::KEY_PORT_W'($urandom_range(0, 15));
    if (r < 8) return {$urandom, $urandom};
    if (r == 8) return '1;
    return $urandom_range(0, 1) ? {1'b1, {(tks_pkg::KEY_PORT_W-1){1'b0}}} : '0;
  endfunction

  task automatic plan_request(input logic [tks_pkg::REQ_W-1:0]      req,
                              input logic [tks_pkg::KEY_PORT_W-1:0] key,
                              input logic [tks_pkg::ROW_PORT_W-1:0] row);
    plan_step_t s;
    s.kind    = DO_REQUEST;
    s.req     = req;
    s.key     = key;
    s.row     = row;
    s.reg_idx = '0;
    s.reg_val = '0;
    request_plan = {request_plan, s};
    planned_items++;
  endtask

  task automatic plan_write(input logic [tks_pkg::CFG_IDX_W-1:0] idx, input int val);
    plan_step_t s;
    s.kind    = DO_WRITE;
    s.req     = tks_pkg::REQ_INSERT;
    s.key     = '0;
    s.row     = '0;
    s.reg_idx = idx;
    s.reg_val = tks_pkg::CFG_W'(val);
    request_plan = {request_plan, s};
  endtask

  task automatic plan_drain();
    plan_step_t s;
    s.kind    = DO_DRAIN;
    s.req     = tks_pkg::REQ_INSERT;
    s.key     = '0;
    s.row     = '0;
    s.reg_idx = '0;
    s.reg_val = '0;
    request_plan = {request_plan, s};
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  // Request driver: hold valid and payload until accepted, then advance.
  // Register writes and drain points wait for a quiet block.
  always @(posedge clk) begin : drive_requests
    logic                           nxt_valid;
    logic [tks_pkg::REQ_W-1:0]      nxt_req;
    logic [tks_pkg::KEY_PORT_W-1:0] nxt_key;
    logic [tks_pkg::ROW_PORT_W-1:0] nxt_row;
    logic                           nxt_wr;
    logic [tks_pkg::CFG_IDX_W-1:0]  nxt_idx;
    logic [tks_pkg::CFG_W-1:0]      nxt_data;
    plan_step_t                     step;
    nxt_valid = in_valid;
    nxt_req   = in_req_type;
    nxt_key   = in_sort_key;
    nxt_row   = in_row_index;
    nxt_wr    = 1'b0;
    nxt_idx   = cfg_index;
    nxt_data  = cfg_wdata;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        // Predict at acceptance; configuration never changes mid-flight
        update_selection(in_req_type, in_sort_key, in_row_index);
        nxt_valid  = 1'b0;
        send_pause = pick_pause(send_calm);
        if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
      end
      // Count cycles with nothing in flight and nothing owed
      if (in_valid || out_valid || due_results.size() != 0) begin
        quiet_run = 0;
      end else if (quiet_run < QUIET_CYCLES) begin
        quiet_run++;
      end
      if (!nxt_valid && request_plan.size() != 0) begin
        step = request_plan[0];
        if (step.kind == DO_REQUEST) begin
          if (send_pause > 0) begin
            send_pause--;
          end else begin
            nxt_valid = 1'b1;
            nxt_req   = step.req;
            nxt_key   = step.key;
            nxt_row   = step.row;
            void'(request_plan.pop_front());
          end
        end else if (quiet_run >= QUIET_CYCLES) begin
          if (step.kind == DO_WRITE) begin
            nxt_wr   = 1'b1;
            nxt_idx  = step.reg_idx;
            nxt_data = step.reg_val;
            if (step.reg_idx == tks_pkg::REG_KEEP_COUNT) keep_lim = step.reg_val;
            else skip_lim = step.reg_val;
          end
          // A drain point just drops out once everything has come back
          void'(request_plan.pop_front());
        end
      end
    end
    in_valid     <= nxt_valid;
    in_req_type  <= nxt_req;
    in_sort_key  <= nxt_key;
    in_row_index <= nxt_row;
    cfg_wr_en    <= nxt_wr;
    cfg_index    <= nxt_idx;
    cfg_wdata    <= nxt_data;
  end

  // Result monitor: compare each accepted result with the oldest prediction,
  // and stall ready at random, both during bursts and between them
  always @(posedge clk) begin : watch_results
    result_t want;
    logic    nxt_ready;
    nxt_ready = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          fault_count++;
          $display("%0t: result with none expected, expected nothing got kind %0d key %h row %h",
                   $time, out_result_kind, out_key, out_row);
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", 64'(want.kind), 64'(out_result_kind));
          check_field("accepted",    64'(want.acc),  64'(out_accepted));
          check_field("store_full",  64'(want.full), 64'(out_store_full));
          check_field("out_key",     64'(want.key),  64'(out_key));
          check_field("out_row",     64'(want.row),  64'(out_row));
          check_field("last",        64'(want.last), 64'(out_last));
        end
        recv_pause = pick_pause(recv_calm);
        if ($urandom_range(0, 59) == 0) recv_calm = !recv_calm;
      end else if (recv_pause == 0 && $urandom_range(0, 15) == 0) begin
        recv_pause = pick_pause(recv_calm);
      end
      if (recv_pause > 0) begin
        recv_pause--;
      end else begin
        nxt_ready = 1'b1;
      end
    end
    out_ready <= nxt_ready;
  end

  // Hard stop: far above every request being a 64-entry scan with long stalls
  initial begin : watchdog
    #100_000_000;
    $display("tb: errors");
    $finish;
  end

  // Fill the plan, release reset, and wait for everything to come back
  initial begin : stimulus
    int phase;
    int n;
    int k;
    int r;
    int sel;
    int keep_v;
    int skip_v;

    // Defaults keep 64, skip 0: empty scan, key extremes, a tie, ignored code
    plan_request(tks_pkg::REQ_SCAN,   '0, '0);
    plan_request(tks_pkg::REQ_INSERT, '0, '0);
    plan_request(tks_pkg::REQ_INSERT, '1, '1);
    plan_request(tks_pkg::REQ_INSERT, 64'd5, 32'd1);
    plan_request(tks_pkg::REQ_INSERT, 64'd5, 32'd2);
    plan_request(tks_pkg::REQ_SCAN,   '0, '0);
    plan_request(REQ_UNUSED, {$urandom, $urandom}, $urandom);
    plan_request(tks_pkg::REQ_CLEAR,  '0, '0);
    plan_request(tks_pkg::REQ_SCAN,   '0, '0);

    // Limit 3 with offset 1: fill, evict on smaller keys, evict among ties,
    // reject a larger key, then scan past the skipped entry
    plan_write(tks_pkg::REG_KEEP_COUNT, 2);
    plan_write(tks_pkg::REG_SKIP_COUNT, 1);
    plan_request(tks_pkg::REQ_INSERT, 64'd9,  32'd10);
    plan_request(tks_pkg::REQ_INSERT, 64'd7,  32'd11);
    plan_request(tks_pkg::REQ_INSERT, 64'd7,  32'd12);
    plan_request(tks_pkg::REQ_INSERT, 64'd8,  32'd13);
    plan_request(tks_pkg::REQ_INSERT, 64'd7,  32'd14);
    plan_request(tks_pkg::REQ_INSERT, 64'd10, 32'd15);
    plan_request(tks_pkg::REQ_SCAN,   '0, '0);

    // Lower the limit below the occupancy; a scan with keep zero is silent
    plan_write(tks_pkg::REG_KEEP_COUNT, 0);
    plan_request(tks_pkg::REQ_INSERT, 64'd1, 32'd16);
    plan_request(tks_pkg::REQ_SCAN,   '0, '0);

    // Limit zero: still evicts while entries remain, rejects once empty
    plan_write(tks_pkg::REG_SKIP_COUNT, 0);
    plan_request(tks_pkg::REQ_INSERT, 64'd0, 32'd17);
    plan_request(tks_pkg::REQ_CLEAR,  '0, '0);
    plan_request(tks_pkg::REQ_INSERT, 64'd3, 32'd18);

    // Skip beyond the occupancy: the scan gives nothing
    plan_write(tks_pkg::REG_KEEP_COUNT, 1);
    plan_write(tks_pkg::REG_SKIP_COUNT, 5);
    plan_request(tks_pkg::REQ_INSERT, 64'd4, 32'd19);
    plan_request(tks_pkg::REQ_SCAN,   '0, '0);

    // Random phases: a setting, then mostly inserts closed by a scan
    phase = 0;
    while (planned_items < ITEM_TARGET) begin
      sel = (phase < 4) ? phase : $urandom_range(0, 9);
      case (sel)
        0: begin keep_v = 64; skip_v = 64; end
        1: begin keep_v = 0;  skip_v = $urandom_range(0, 6); end
        2: begin keep_v = 64; skip_v = 0; end
        3: begin keep_v = $urandom_range(1, 6); skip_v = 64; end
        4: begin keep_v = $urandom_range(40, 64); skip_v = $urandom_range(0, 20); end
        default: begin
          keep_v = $urandom_range(1, 8);
          skip_v = $urandom_range(0, 4);
        end
      endcase
      plan_write(tks_pkg::REG_KEEP_COUNT, keep_v);
      plan_write(tks_pkg::REG_SKIP_COUNT, skip_v);
      n = $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) plan_request(tks_pkg::REQ_CLEAR, pick_key(), $urandom);
      for (k = 0; k < n; k++) begin
        // Hold off the sender mid-phase until every result is back
        if (phase % 4 == 1 && k == n / 2) plan_drain();
        r = $urandom_range(0, 99);
        if (r < 72) plan_request(tks_pkg::REQ_INSERT, pick_key(), $urandom);
        else if (r < 86) plan_request(tks_pkg::REQ_SCAN, pick_key(), $urandom);
        else if (r < 92) plan_request(tks_pkg::REQ_CLEAR, pick_key(), $urandom);
        else plan_request(REQ_UNUSED, pick_key(), $urandom);
      end
      plan_request(tks_pkg::REQ_SCAN, pick_key(), $urandom);
      phase++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (request_plan.size() != 0 || in_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tks_pkg.sv
rtl/tks_cell.sv
rtl/tks_chain.sv
rtl/top_k_smallest_selector.sv
sim/tb.sv
